@@ rtl/double_hash_table_engine_assert.svh @@
// Assertion macros for the double hash table engine.
// Included by the top level; has no other dependencies.
`ifndef DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DHTE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dhte assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define DHTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dhte assertion failed");
`else
`define DHTE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define DHTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/dhte_pkg.sv @@
// Shared types and constants for the double hash table engine.
// No dependencies.
package dhte_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int SIZE_W        = ADDR_W + 1;
    localparam int KEY_W         = 64;

    // Operation codes.
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_MISS        = 3'd1;
    localparam logic [2:0] ST_INSERTED    = 3'd2;
    localparam logic [2:0] ST_OVERWRITTEN = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_CLEARED     = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] search_key;
        logic [63:0] entry_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_data;
        logic [11:0] slot_index;
        logic [12:0] probe_count;
    } out_item_t;

    // Classified operation passed from the front end to the probe engine.
    typedef struct packed {
        logic [1:0]               kind;
        logic [KEY_W-1:0]         key;
        logic [PAYLOAD_WIDTH-1:0] data;
        logic [ADDR_W-1:0]        start;
        logic [ADDR_W-1:0]        step;
        logic [SIZE_W-1:0]        size;
    } q_item_t;

    // Status from the probe engine.
    typedef struct packed {
        logic init_busy;
    } back_stat_t;

endpackage

@@ rtl/dhte_front.sv @@
// Front end: accepts items, holds the size register and computes the start
// slot and probe step with a bit-serial remainder unit. Uses dhte_pkg.
module dhte_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [12:0]                   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dhte_pkg::in_item_t            s_item,
    input  dhte_pkg::back_stat_t          back_stat,
    output logic                          push_valid,
    input  logic                          push_ready,
    output dhte_pkg::q_item_t             push_item
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t                        state_reg, state_next;
    logic [12:0]                    size_cfg_reg;
    dhte_pkg::in_item_t             item_reg, item_next;
    logic [dhte_pkg::KEY_W-1:0]     shift_reg, shift_next;
    logic [dhte_pkg::SIZE_W-1:0]    n_reg, n_next;
    logic [dhte_pkg::SIZE_W-1:0]    rn_reg, rn_next;
    logic [dhte_pkg::SIZE_W-1:0]    rm_reg, rm_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic [dhte_pkg::SIZE_W-1:0]    n_clamped;
    logic [dhte_pkg::SIZE_W:0]      trial_n, trial_m;
    logic [dhte_pkg::SIZE_W-1:0]    m_div;

    // Size register, written whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= 13'(dhte_pkg::TABLE_DEPTH);
        end else if (cfg_wr_en) begin
            size_cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp the configured size into the usable range.
    always_comb begin
        if (size_cfg_reg < 13'd2) begin
            n_clamped = dhte_pkg::SIZE_W'(2);
        end else if (size_cfg_reg > 13'(dhte_pkg::TABLE_DEPTH)) begin
            n_clamped = dhte_pkg::SIZE_W'(dhte_pkg::TABLE_DEPTH);
        end else begin
            n_clamped = dhte_pkg::SIZE_W'(size_cfg_reg);
        end
    end

    // One restoring remainder step for each divisor per cycle.
    assign m_div   = n_reg - dhte_pkg::SIZE_W'(1);
    assign trial_n = {rn_reg, shift_reg[dhte_pkg::KEY_W-1]};
    assign trial_m = {rm_reg, shift_reg[dhte_pkg::KEY_W-1]};

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        shift_next = shift_reg;
        n_next     = n_reg;
        rn_next    = rn_reg;
        rm_next    = rm_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next  = s_item;
                    shift_next = s_item.search_key;
                    n_next     = n_clamped;
                    rn_next    = '0;
                    rm_next    = '0;
                    cnt_next   = '0;
                    state_next = (s_item.kind == dhte_pkg::KIND_CLEAR) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                rn_next = (trial_n >= {1'b0, n_reg}) ? dhte_pkg::SIZE_W'(trial_n - {1'b0, n_reg})
                                                     : dhte_pkg::SIZE_W'(trial_n);
                rm_next = (trial_m >= {1'b0, m_div}) ? dhte_pkg::SIZE_W'(trial_m - {1'b0, m_div})
                                                     : dhte_pkg::SIZE_W'(trial_m);
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg  <= item_next;
        shift_reg <= shift_next;
        n_reg     <= n_next;
        rn_reg    <= rn_next;
        rm_reg    <= rm_next;
        cnt_reg   <= cnt_next;
    end

    // Items are taken only while idle and after the power-up clearing pass.
    assign s_ready    = (state_reg == F_IDLE) && !back_stat.init_busy;
    assign push_valid = (state_reg == F_PUSH);

    always_comb begin
        push_item.kind  = item_reg.kind;
        push_item.key   = item_reg.search_key;
        push_item.data  = item_reg.entry_data[dhte_pkg::PAYLOAD_WIDTH-1:0];
        push_item.start = rn_reg[dhte_pkg::ADDR_W-1:0];
        push_item.step  = rm_reg[dhte_pkg::ADDR_W-1:0];
        push_item.size  = n_reg;
    end

endmodule

@@ rtl/dhte_queue.sv @@
// Two-entry queue between the front end and the probe engine.
// Uses dhte_pkg.
module dhte_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  dhte_pkg::q_item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output dhte_pkg::q_item_t pop_item
);

    dhte_pkg::q_item_t entry_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/dhte_back.sv @@
// Probe engine: owns the slot memory, walks the probe sequence and
// registers one result per item. Uses dhte_pkg.
module dhte_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  dhte_pkg::q_item_t     pop_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dhte_pkg::out_item_t   m_item,
    output dhte_pkg::back_stat_t  back_stat
);

    typedef enum logic [2:0] {B_INIT, B_IDLE, B_READ, B_CMP, B_CLEAR} bstate_t;

    typedef struct packed {
        logic                               valid;
        logic [dhte_pkg::KEY_W-1:0]         key;
        logic [dhte_pkg::PAYLOAD_WIDTH-1:0] payload;
    } slot_word_t;

    localparam logic [dhte_pkg::ADDR_W-1:0] LAST_ADDR = dhte_pkg::ADDR_W'(dhte_pkg::TABLE_DEPTH - 1);

    slot_word_t                   mem [dhte_pkg::TABLE_DEPTH];
    slot_word_t                   rdata_reg;

    bstate_t                      state_reg, state_next;
    dhte_pkg::q_item_t            cur_reg, cur_next;
    logic [dhte_pkg::ADDR_W-1:0]  slot_reg, slot_next;
    logic [dhte_pkg::SIZE_W-1:0]  probes_reg, probes_next;
    logic [dhte_pkg::ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    dhte_pkg::out_item_t          res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;

    logic                         out_free, is_insert, key_match, finish;
    logic [dhte_pkg::SIZE_W-1:0]  probes_now, sum, next_slot;
    logic                         mem_we;
    logic [dhte_pkg::ADDR_W-1:0]  mem_waddr;
    slot_word_t                   mem_wdata;

    assign out_free   = !res_valid_reg || m_ready;
    assign is_insert  = (cur_reg.kind == dhte_pkg::KIND_INSERT);
    assign key_match  = (rdata_reg.key == cur_reg.key);
    assign probes_now = probes_reg + dhte_pkg::SIZE_W'(1);
    assign finish     = !rdata_reg.valid || key_match || (probes_now == cur_reg.size);

    // Next probe slot: both terms are below the size, so one subtract wraps it.
    assign sum       = {1'b0, slot_reg} + {1'b0, cur_reg.step};
    assign next_slot = (sum >= cur_reg.size) ? (sum - cur_reg.size) : sum;

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        probes_next    = probes_reg;
        clr_addr_next  = clr_addr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !m_ready;
        pop_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '{valid: 1'b1, key: cur_reg.key, payload: cur_reg.data};
        case (state_reg)
            // Sweep every slot empty after reset.
            B_INIT: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + dhte_pkg::ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    cur_next      = pop_item;
                    slot_next     = pop_item.start;
                    probes_next   = '0;
                    clr_addr_next = '0;
                    state_next    = (pop_item.kind == dhte_pkg::KIND_CLEAR) ? B_CLEAR : B_READ;
                end
            end
            B_READ: begin
                state_next = B_CMP;
            end
            // Slot data is in rdata_reg; decide hit, miss, write or next probe.
            B_CMP: begin
                if (!finish) begin
                    probes_next = probes_now;
                    slot_next   = next_slot[dhte_pkg::ADDR_W-1:0];
                    state_next  = B_READ;
                end else if (out_free) begin
                    mem_we                 = is_insert && (!rdata_reg.valid || key_match);
                    res_valid_next         = 1'b1;
                    res_next.slot_index    = slot_reg;
                    res_next.probe_count   = probes_now;
                    res_next.found_data    = '0;
                    if (!rdata_reg.valid) begin
                        res_next.status = is_insert ? dhte_pkg::ST_INSERTED : dhte_pkg::ST_MISS;
                    end else if (key_match) begin
                        res_next.status = is_insert ? dhte_pkg::ST_OVERWRITTEN
                                                    : dhte_pkg::ST_HIT;
                        if (!is_insert) begin
                            res_next.found_data = 64'(rdata_reg.payload);
                        end
                    end else begin
                        res_next.status = is_insert ? dhte_pkg::ST_FULL : dhte_pkg::ST_MISS;
                    end
                    state_next = B_IDLE;
                end
            end
            // Clear operation: sweep the memory, then report.
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg != LAST_ADDR) begin
                    clr_addr_next = clr_addr_reg + dhte_pkg::ADDR_W'(1);
                end else if (out_free) begin
                    res_valid_next       = 1'b1;
                    res_next.status      = dhte_pkg::ST_CLEARED;
                    res_next.found_data  = '0;
                    res_next.slot_index  = '0;
                    res_next.probe_count = '0;
                    state_next           = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_INIT;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        res_reg    <= res_next;
    end

    assign m_valid             = res_valid_reg;
    assign m_item              = res_reg;
    assign back_stat.init_busy = (state_reg == B_INIT);

endmodule

@@ rtl/double_hash_table_engine.sv @@
// Top level of the double hash table engine: front end, queue, probe engine.
// Uses dhte_pkg, dhte_front, dhte_queue, dhte_back and the assertion header.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  dhte_pkg::in_item_t
// m_        out        m_valid / m_ready  dhte_pkg::out_item_t
// cfg_wr_   in         cfg_wr_en only     table_size, 13 bits
//
// The front end runs the two serial remainders for each lookup or insert; a clear
// skips them. The probe engine reads each probed slot in B_READ and compares it in
// B_CMP; a clear sweeps all 4096 slots. Items overlap between the two parts.
// After reset a clearing pass sweeps every slot; s_ready stays low until it ends.
// A stalled m_ready holds the result register and, behind it, the probe engine.
`include "double_hash_table_engine_assert.svh"

module double_hash_table_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [12:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  dhte_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output dhte_pkg::out_item_t m_item
);

    logic                 push_valid, push_ready, pop_valid, pop_ready;
    dhte_pkg::q_item_t    push_item, pop_item;
    dhte_pkg::back_stat_t back_stat;

    dhte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .back_stat   (back_stat),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    dhte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dhte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .back_stat (back_stat)
    );

    // A clear result carries no slot and no probe count.
    `DHTE_ASSERT_NOW(a_clear_result, aclk, aresetn, m_valid && (m_item.status == dhte_pkg::ST_CLEARED), (m_item.probe_count == 13'd0) && (m_item.slot_index == 12'd0))
    // Every search result probed at least one slot, never more than the table holds.
    `DHTE_ASSERT_NOW(a_probe_range, aclk, aresetn, m_valid && (m_item.status != dhte_pkg::ST_CLEARED), (m_item.probe_count != 13'd0) && (m_item.probe_count <= 13'(dhte_pkg::TABLE_DEPTH)))
    // No item enters while the power-up clearing pass is still running.
    `DHTE_ASSERT_NOW(a_no_accept_init, aclk, aresetn, back_stat.init_busy, !(s_valid && s_ready) && !pop_ready)
    // Only hits return a payload.
    `DHTE_ASSERT_NOW(a_data_on_hit, aclk, aresetn, m_valid && (m_item.status != dhte_pkg::ST_HIT), m_item.found_data == 64'd0)

endmodule

@@ tb/sv/double_hash_table_engine_test.sv @@
// Testbench for the double hash table engine: directed and random lookups,
// inserts and clears checked against a behavioral table model.
// Depends on dhte_pkg and the double_hash_table_engine RTL.
`timescale 1ns / 1ps

// Keeps a behavioral copy of the table and the queue of predicted results.
class hash_table_scoreboard;
    bit [12:0]           size_reg;
    bit                  valid_bits [dhte_pkg::TABLE_DEPTH];
    bit [63:0]           keys [dhte_pkg::TABLE_DEPTH];
    bit [63:0]           payloads [dhte_pkg::TABLE_DEPTH];
    dhte_pkg::out_item_t pending [$];
    int                  errors;

    function new();
        size_reg = 13'd4096;
        errors = 0;
        foreach (valid_bits[i]) valid_bits[i] = 1'b0;
    endfunction

    function void set_size(bit [12:0] v);
        size_reg = v;
    endfunction

    // Walks the probe sequence for one accepted item and queues its result.
    function void note_item(dhte_pkg::in_item_t it);
        dhte_pkg::out_item_t r;
        longint unsigned n, stride, s, i;
        bit ins, done;
        r = '0;
        if (it.kind == dhte_pkg::KIND_CLEAR) begin
            foreach (valid_bits[j]) valid_bits[j] = 1'b0;
            r.status = dhte_pkg::ST_CLEARED;
        end else begin
            n = size_reg < 2 ? 2 : (size_reg > dhte_pkg::TABLE_DEPTH ?
                                    dhte_pkg::TABLE_DEPTH : size_reg);
            stride = it.search_key % (n - 1);
            s = it.search_key % n;
            ins = (it.kind == dhte_pkg::KIND_INSERT);
            done = 1'b0;
            r.status = ins ? dhte_pkg::ST_FULL : dhte_pkg::ST_MISS;
            for (i = 0; i < n && !done; i++) begin
                r.slot_index = s[11:0];
                r.probe_count = 13'(i + 1);
                if (!valid_bits[s]) begin
                    if (ins) begin
                        valid_bits[s] = 1'b1;
                        keys[s] = it.search_key;
                        payloads[s] = it.entry_data;
                        r.status = dhte_pkg::ST_INSERTED;
                    end else begin
                        r.status = dhte_pkg::ST_MISS;
                    end
                    done = 1'b1;
                end else if (keys[s] == it.search_key) begin
                    if (ins) begin
                        payloads[s] = it.entry_data;
                        r.status = dhte_pkg::ST_OVERWRITTEN;
                    end else begin
                        r.found_data = payloads[s];
                        r.status = dhte_pkg::ST_HIT;
                    end
                    done = 1'b1;
                end
                s = (s + stride) % n;
            end
        end
        pending = {pending, r};
    endfunction

    // Compares one result with the oldest prediction.
    function void check_result(dhte_pkg::out_item_t got);
        dhte_pkg::out_item_t want;
        if (pending.size() == 0) begin
            $error("unexpected result item status=%0d", got.status);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.found_data !== want.found_data) begin
            $error("found_data expected %h actual %h", want.found_data, got.found_data);
            errors++;
        end
        if (got.slot_index !== want.slot_index) begin
            $error("slot_index expected %0d actual %0d", want.slot_index, got.slot_index);
            errors++;
        end
        if (got.probe_count !== want.probe_count) begin
            $error("probe_count expected %0d actual %0d", want.probe_count,
                   got.probe_count);
            errors++;
        end
    endfunction
endclass

module double_hash_table_engine_test;
    // The spare operation code behaves as a lookup.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [12:0]         cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    dhte_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    dhte_pkg::out_item_t m_item;

    hash_table_scoreboard table_sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit [63:0] recent_keys [$];

    double_hash_table_engine DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #50ms;
        $display("double_hash_table_engine_test failed");
        $finish;
    end

    // Result side: random stalls, check on every accepted item.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) table_sb.check_result(m_item);
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one item, with a random gap first, and waits for acceptance.
    // Valid stays high into the next item when there is no gap.
    task automatic send_item(bit [1:0] kind, bit [63:0] key, bit [63:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item <= '{kind: kind, search_key: key, entry_data: data};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        table_sb.note_item('{kind: kind, search_key: key, entry_data: data});
        @(negedge aclk);
    endtask

    // Waits for all results, lets the engine settle, then writes the size.
    task automatic write_size(bit [12:0] v);
        s_valid <= 1'b0;
        while (table_sb.pending.size() != 0) @(negedge aclk);
        repeat (4200) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        table_sb.set_size(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Reuses a recent key about half the time so that hits and overwrites happen.
    task automatic random_items(int count);
        bit [63:0] key;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (recent_keys.size() != 0 && $urandom_range(1))
                key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else begin
                key = {$urandom, $urandom};
                recent_keys = {recent_keys, key};
                if (recent_keys.size() > 40) void'(recent_keys.pop_front());
            end
            if (pick < 2)
                send_item(dhte_pkg::KIND_CLEAR, key, {$urandom, $urandom});
            else if (pick < 5)
                send_item(KIND_SPARE, key, {$urandom, $urandom});
            else if (pick < 50)
                send_item(dhte_pkg::KIND_INSERT, key, {$urandom, $urandom});
            else
                send_item(dhte_pkg::KIND_LOOKUP, key, {$urandom, $urandom});
        end
    endtask

    initial begin
        table_sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 74;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of key and payload at full size.
        send_item(dhte_pkg::KIND_LOOKUP, 64'd0, 64'd0);
        send_item(dhte_pkg::KIND_INSERT, 64'd0, '1);
        send_item(dhte_pkg::KIND_INSERT, '1, 64'h5555_AAAA_0F0F_F0F0);
        send_item(dhte_pkg::KIND_LOOKUP, '1, 64'd0);
        send_item(dhte_pkg::KIND_INSERT, '1, 64'hAAAA_5555_F0F0_0F0F);
        send_item(KIND_SPARE, 64'd0, 64'd0);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd4096, 64'd0);
        send_item(dhte_pkg::KIND_CLEAR, 64'd0, 64'd0);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd0, 64'd0);

        // Size two: zero step, full table and exhausted lookup.
        write_size(13'd0);
        send_item(dhte_pkg::KIND_INSERT, 64'd2, 64'd11);
        send_item(dhte_pkg::KIND_INSERT, 64'd3, 64'd12);
        send_item(dhte_pkg::KIND_INSERT, 64'd5, 64'd13);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd7, 64'd0);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd4, 64'd0);

        // Small size, then raise it: old slots become reachable again.
        write_size(13'd7);
        send_item(dhte_pkg::KIND_INSERT, 64'd6, 64'd1);
        send_item(dhte_pkg::KIND_INSERT, 64'd13, 64'd2);
        send_item(dhte_pkg::KIND_INSERT, 64'd20, 64'd3);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd27, 64'd0);
        random_items(120);

        write_size(13'd8191);
        send_item(dhte_pkg::KIND_LOOKUP, 64'd6, 64'd0);
        random_items(60);

        send_idle_pct = 74;
        recv_idle_pct = 36;
        write_size(13'd3);
        random_items(100);
        write_size(13'd33);
        random_items(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(13'd4096);
        random_items(50);
        s_valid <= 1'b0;

        while (table_sb.pending.size() != 0) @(negedge aclk);
        repeat (4200) @(negedge aclk);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0)
            $display("double_hash_table_engine_test passed");
        else
            $display("double_hash_table_engine_test failed");
        $finish;
    end
endmodule
